// ===== src/dpcd_pkg.sv =====
`default_nettype none

package dpcd_pkg;

  localparam int LEVEL_BITS_DEFAULT = 8;
  localparam int PHASE_BITS_DEFAULT = 10;

  localparam int FIRST_DELAY_RESET  = 30;
  localparam int SECOND_DELAY_RESET = 565;
  localparam int PHASE_LIMIT_RESET  = 1000;

  localparam int ACTION_BITS    = 2;
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_TICK       = 2'd0,
    ACT_ZERO_CROSS = 2'd1,
    ACT_SET_LEVELS = 2'd2
  } action_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FIRST_FIRE_DELAY  = 2'd0,
    REG_SECOND_FIRE_DELAY = 2'd1,
    REG_PHASE_LIMIT       = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/dpcd_cmd_if.sv =====
`default_nettype none

interface dpcd_cmd_if #(
  parameter int LEVEL_BITS = dpcd_pkg::LEVEL_BITS_DEFAULT
);
  logic                               valid;
  logic                               ready;
  logic [dpcd_pkg::ACTION_BITS-1:0]   action;
  logic [LEVEL_BITS-1:0]              level_one;
  logic [LEVEL_BITS-1:0]              level_two;

  modport source (output valid, output action, output level_one, output level_two,
                  input ready);
  modport sink   (input valid, input action, input level_one, input level_two,
                  output ready);
endinterface

`default_nettype wire

// ===== src/dpcd_drv_if.sv =====
`default_nettype none

interface dpcd_drv_if;
  logic valid;
  logic ready;
  logic drive_one;
  logic drive_two;

  modport source (output valid, output drive_one, output drive_two, input ready);
  modport sink   (input valid, input drive_one, input drive_two, output ready);
endinterface

`default_nettype wire

// ===== src/dpcd_cfg.sv =====
`default_nettype none

module dpcd_cfg #(
  parameter int PHASE_BITS = dpcd_pkg::PHASE_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [dpcd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [PHASE_BITS-1:0]                 cfg_data,
  output logic      [PHASE_BITS-1:0]                 first_fire_delay,
  output logic      [PHASE_BITS-1:0]                 second_fire_delay,
  output logic      [PHASE_BITS-1:0]                 phase_limit
);
  import dpcd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_fire_delay  <= PHASE_BITS'(FIRST_DELAY_RESET);
      second_fire_delay <= PHASE_BITS'(SECOND_DELAY_RESET);
      phase_limit       <= PHASE_BITS'(PHASE_LIMIT_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIRST_FIRE_DELAY:  first_fire_delay  <= cfg_data;
        REG_SECOND_FIRE_DELAY: second_fire_delay <= cfg_data;
        REG_PHASE_LIMIT:       phase_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/dpcd_in_reg.sv =====
`default_nettype none

module dpcd_in_reg #(
  parameter int LEVEL_BITS = dpcd_pkg::LEVEL_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  dpcd_cmd_if.sink  up,
  dpcd_cmd_if.source down
);
  import dpcd_pkg::*;

  logic                   full;
  logic [ACTION_BITS-1:0] hold_action;
  logic [LEVEL_BITS-1:0]  hold_level_one;
  logic [LEVEL_BITS-1:0]  hold_level_two;

  assign up.ready = !full || down.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (up.ready) begin
      full <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up.ready) begin
      hold_action    <= up.action;
      hold_level_one <= up.level_one;
      hold_level_two <= up.level_two;
    end
  end

  assign down.valid     = full;
  assign down.action    = hold_action;
  assign down.level_one = hold_level_one;
  assign down.level_two = hold_level_two;

endmodule

`default_nettype wire

// ===== src/dpcd_engine.sv =====
`default_nettype none

module dpcd_engine #(
  parameter int LEVEL_BITS = dpcd_pkg::LEVEL_BITS_DEFAULT,
  parameter int PHASE_BITS = dpcd_pkg::PHASE_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [PHASE_BITS-1:0] first_fire_delay,
  input  wire logic [PHASE_BITS-1:0] second_fire_delay,
  input  wire logic [PHASE_BITS-1:0] phase_limit,
  dpcd_cmd_if.sink                   cmd,
  dpcd_drv_if.source                 drv
);
  import dpcd_pkg::*;

  logic                  accept;
  logic [PHASE_BITS-1:0] phase_count, phase_count_next, phase_step;
  logic                  half_rate_toggle, half_rate_toggle_next;
  logic [LEVEL_BITS-1:0] count_one, count_one_next, count_one_fired;
  logic [LEVEL_BITS-1:0] count_two, count_two_next, count_two_fired;
  logic [LEVEL_BITS-1:0] bright_one, bright_one_next;
  logic [LEVEL_BITS-1:0] bright_two, bright_two_next;
  logic                  switch_one, switch_one_next, switch_one_fired;
  logic                  switch_two, switch_two_next, switch_two_fired;
  logic                  fire;
  logic                  out_valid;

  assign cmd.ready = !out_valid || drv.ready;
  assign accept    = cmd.valid && cmd.ready;

  // tick path: phase step, fire check, half-rate count
  assign phase_step = (phase_count < phase_limit) ? phase_count + 1'b1 : phase_count;
  assign fire = (phase_step == first_fire_delay) || (phase_step == second_fire_delay);

  assign count_one_fired  = fire ? '0 : count_one;
  assign count_two_fired  = fire ? '0 : count_two;
  assign switch_one_fired = switch_one || (fire && (bright_one != '0));
  assign switch_two_fired = switch_two || (fire && (bright_two != '0));

  always_comb begin
    phase_count_next      = phase_count;
    half_rate_toggle_next = half_rate_toggle;
    count_one_next        = count_one;
    count_two_next        = count_two;
    bright_one_next       = bright_one;
    bright_two_next       = bright_two;
    switch_one_next       = switch_one;
    switch_two_next       = switch_two;
    case (action_t'(cmd.action))
      ACT_TICK: begin
        phase_count_next      = phase_step;
        half_rate_toggle_next = !half_rate_toggle;
        count_one_next        = count_one_fired;
        count_two_next        = count_two_fired;
        switch_one_next       = switch_one_fired;
        switch_two_next       = switch_two_fired;
        if (half_rate_toggle) begin
          if (count_one_fired >= bright_one) begin
            switch_one_next = 1'b0;
          end else begin
            count_one_next = count_one_fired + 1'b1;
          end
          if (count_two_fired >= bright_two) begin
            switch_two_next = 1'b0;
          end else begin
            count_two_next = count_two_fired + 1'b1;
          end
        end
      end
      ACT_ZERO_CROSS: begin
        phase_count_next = '0;
      end
      ACT_SET_LEVELS: begin
        bright_one_next = cmd.level_one;
        bright_two_next = cmd.level_two;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count      <= '0;
      half_rate_toggle <= 1'b0;
      count_one        <= '0;
      count_two        <= '0;
      bright_one       <= '0;
      bright_two       <= '0;
      switch_one       <= 1'b0;
      switch_two       <= 1'b0;
    end else if (accept) begin
      phase_count      <= phase_count_next;
      half_rate_toggle <= half_rate_toggle_next;
      count_one        <= count_one_next;
      count_two        <= count_two_next;
      bright_one       <= bright_one_next;
      bright_two       <= bright_two_next;
      switch_one       <= switch_one_next;
      switch_two       <= switch_two_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (drv.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign drv.valid     = out_valid;
  assign drv.drive_one = switch_one;
  assign drv.drive_two = switch_two;

`ifndef SYNTH
  a_beat_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> drv.valid)
    else $error("accepted beat produced no result");

  a_zero_cross_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == ACT_ZERO_CROSS) |=> phase_count == '0)
    else $error("zero-cross did not clear phase counter");

  a_levels_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd.action == ACT_SET_LEVELS)
    |=> (bright_one == $past(cmd.level_one)) && (bright_two == $past(cmd.level_two)))
    else $error("levels not loaded");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    drv.valid |-> (drv.drive_one == switch_one) && (drv.drive_two == switch_two))
    else $error("result differs from switch state");
`endif

endmodule

`default_nettype wire

// ===== src/dual_phase_cut_dimmer.sv =====
// two-channel trailing-edge phase-cut dimmer timer
// cmd channel: one beat per event; action selects timer tick, zero-cross edge
//   or set levels (level_one, level_two taken only for set levels)
// drv channel: one beat per cmd beat, carrying drive_one and drive_two as the
//   switch states right after that event
// config port: cfg_we with cfg_index 0 first fire delay, 1 second fire delay,
//   2 phase limit; index 3 is ignored; write only while the block is idle
// latency: a cmd beat accepted at edge n gives its drv beat valid after edge
//   n+1 (input register, then update logic into the result register)
// throughput: one beat per cycle, set by the single-cycle state update
// reset: phase and channel counters, levels and switches cleared, delays
//   back to 30 and 565, limit back to 1000, both channels idle
// stall: when drv is not taken, the result register holds its beat and the
//   input register takes one more; cmd ready then drops until drv drains
`default_nettype none

module dual_phase_cut_dimmer #(
  parameter int LEVEL_BITS = dpcd_pkg::LEVEL_BITS_DEFAULT,
  parameter int PHASE_BITS = dpcd_pkg::PHASE_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [dpcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [PHASE_BITS-1:0]               cfg_data,
  dpcd_cmd_if.sink                                 cmd,
  dpcd_drv_if.source                               drv
);
  import dpcd_pkg::*;

  logic [PHASE_BITS-1:0] first_fire_delay;
  logic [PHASE_BITS-1:0] second_fire_delay;
  logic [PHASE_BITS-1:0] phase_limit;

  dpcd_cmd_if #(.LEVEL_BITS(LEVEL_BITS)) staged ();

  dpcd_cfg #(.PHASE_BITS(PHASE_BITS)) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .first_fire_delay  (first_fire_delay),
    .second_fire_delay (second_fire_delay),
    .phase_limit       (phase_limit)
  );

  dpcd_in_reg #(.LEVEL_BITS(LEVEL_BITS)) u_in_reg (
    .clk  (clk),
    .rst  (rst),
    .up   (cmd),
    .down (staged)
  );

  dpcd_engine #(
    .LEVEL_BITS (LEVEL_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_engine (
    .clk               (clk),
    .rst               (rst),
    .first_fire_delay  (first_fire_delay),
    .second_fire_delay (second_fire_delay),
    .phase_limit       (phase_limit),
    .cmd               (staged),
    .drv               (drv)
  );

endmodule

`default_nettype wire

// ===== verif/tb_dual_phase_cut_dimmer.sv =====
`default_nettype none

module tb_dual_phase_cut_dimmer;
  import dpcd_pkg::*;

  localparam int LEVEL_BITS = LEVEL_BITS_DEFAULT;
  localparam int PHASE_BITS = PHASE_BITS_DEFAULT;
  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 115;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic drive_one;
    logic drive_two;
  } drive_pair_t;

  localparam drive_pair_t BOTH_OFF = '{1'b0, 1'b0};

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [ACTION_BITS-1:0]  act;
    logic [LEVEL_BITS-1:0]   lvl_one;
    logic [LEVEL_BITS-1:0]   lvl_two;
    logic                    typed;
    drive_pair_t             want;
    logic [PHASE_BITS-1:0]   first_delay;
    logic [PHASE_BITS-1:0]   second_delay;
    logic [PHASE_BITS-1:0]   limit;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [PHASE_BITS-1:0] cfg_data;

  dpcd_cmd_if #(.LEVEL_BITS(LEVEL_BITS)) cmd_bus ();
  dpcd_drv_if drv_bus ();

  dual_phase_cut_dimmer #(
    .LEVEL_BITS(LEVEL_BITS),
    .PHASE_BITS(PHASE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd_bus),
    .drv      (drv_bus)
  );

  always #2 clk = ~clk;

  // dimmer model state
  logic [PHASE_BITS-1:0] dly_first, dly_second, ph_limit;
  logic [PHASE_BITS-1:0] ph_count;
  logic                  ph_toggle;
  logic [LEVEL_BITS-1:0] ch1_count, ch2_count, ch1_bright, ch2_bright;
  logic                  ch1_switch, ch2_switch;

  drive_pair_t pending_drives[$];
  logic        cmd_typed;
  drive_pair_t cmd_want;

  int stall_pct = 0;
  int send_idle = 0;
  logic pressure_on = 1'b0;
  int hold_count = 0;

  int failures = 0;
  int beats_checked = 0;
  int fire_points = 0;
  int cfg_settings = 0;
  int n_tick = 0, n_zero = 0, n_levels = 0, n_unused = 0;

  function automatic drive_pair_t advance_dimmer(logic [ACTION_BITS-1:0] act,
                                                 logic [LEVEL_BITS-1:0] lvl_one,
                                                 logic [LEVEL_BITS-1:0] lvl_two);
    case (act)
      ACT_TICK: begin
        if (ph_count < ph_limit) ph_count = ph_count + 1'b1;
        if (ph_count == dly_first || ph_count == dly_second) begin
          fire_points++;
          ch1_count = '0;
          ch2_count = '0;
          if (ch1_bright != '0) ch1_switch = 1'b1;
          if (ch2_bright != '0) ch2_switch = 1'b1;
        end
        if (!ph_toggle) begin
          ph_toggle = 1'b1;
        end else begin
          ph_toggle = 1'b0;
          if (ch1_count >= ch1_bright) ch1_switch = 1'b0;
          else ch1_count = ch1_count + 1'b1;
          if (ch2_count >= ch2_bright) ch2_switch = 1'b0;
          else ch2_count = ch2_count + 1'b1;
        end
      end
      ACT_ZERO_CROSS: ph_count = '0;
      ACT_SET_LEVELS: begin
        ch1_bright = lvl_one;
        ch2_bright = lvl_two;
      end
      default: ;
    endcase
    return '{ch1_switch, ch2_switch};
  endfunction

  always @(posedge clk) begin
    drive_pair_t want, got;
    if (rst) begin
      dly_first = PHASE_BITS'(FIRST_DELAY_RESET);
      dly_second = PHASE_BITS'(SECOND_DELAY_RESET);
      ph_limit = PHASE_BITS'(PHASE_LIMIT_RESET);
      ph_count = '0;
      ph_toggle = 1'b0;
      ch1_count = '0;
      ch2_count = '0;
      ch1_bright = '0;
      ch2_bright = '0;
      ch1_switch = 1'b0;
      ch2_switch = 1'b0;
      pending_drives.delete();
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        case (cmd_bus.action)
          ACT_TICK:       n_tick++;
          ACT_ZERO_CROSS: n_zero++;
          ACT_SET_LEVELS: n_levels++;
          default:        n_unused++;
        endcase
        want = advance_dimmer(cmd_bus.action, cmd_bus.level_one, cmd_bus.level_two);
        if (cmd_typed) want = cmd_want;
        pending_drives.push_back(want);
      end
      if (drv_bus.valid && drv_bus.ready) begin
        got = '{drv_bus.drive_one, drv_bus.drive_two};
        if (pending_drives.size() == 0) begin
          if (failures < 10)
            $display("unexpected drive beat %0b/%0b", got.drive_one, got.drive_two);
          failures++;
        end else begin
          want = pending_drives.pop_front();
          beats_checked++;
          if (got != want) begin
            if (failures < 10)
              $display("drive mismatch at beat %0d: expected %0b/%0b got %0b/%0b",
                       beats_checked, want.drive_one, want.drive_two,
                       got.drive_one, got.drive_two);
            failures++;
          end
        end
      end
    end
  end

  // result side backpressure, with one long hold-off
  always @(posedge clk) begin
    if (pressure_on && hold_count < HOLD_CYCLES) begin
      drv_bus.ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      drv_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer_event(input logic [ACTION_BITS-1:0] act,
                             input logic [LEVEL_BITS-1:0] lvl_one,
                             input logic [LEVEL_BITS-1:0] lvl_two,
                             input logic typed, input drive_pair_t want);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.action <= act;
    cmd_bus.level_one <= lvl_one;
    cmd_bus.level_two <= lvl_two;
    cmd_typed <= typed;
    cmd_want <= want;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
  endtask

  task automatic settle();
    cmd_bus.valid <= 1'b0;
    cmd_typed <= 1'b0;
    @(posedge clk);
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic [PHASE_BITS-1:0] first_delay,
                            input logic [PHASE_BITS-1:0] second_delay,
                            input logic [PHASE_BITS-1:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= REG_FIRST_FIRE_DELAY;
    cfg_data <= first_delay;
    @(posedge clk);
    cfg_index <= REG_SECOND_FIRE_DELAY;
    cfg_data <= second_delay;
    @(posedge clk);
    cfg_index <= REG_PHASE_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    dly_first = first_delay;
    dly_second = second_delay;
    ph_limit = limit;
    cfg_settings++;
    @(posedge clk);
  endtask

  function automatic dir_row_t ev_row(logic [ACTION_BITS-1:0] act,
                                      logic [LEVEL_BITS-1:0] lvl_one,
                                      logic [LEVEL_BITS-1:0] lvl_two,
                                      logic typed, drive_pair_t want);
    dir_row_t r;
    r = '{ROW_EVENT, act, lvl_one, lvl_two, typed, want, '0, '0, '0};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(logic [PHASE_BITS-1:0] first_delay,
                                       logic [PHASE_BITS-1:0] second_delay,
                                       logic [PHASE_BITS-1:0] limit);
    dir_row_t r;
    r = '{ROW_CONFIG, ACT_TICK, '0, '0, 1'b0, BOTH_OFF, first_delay, second_delay, limit};
    return r;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    logic [PHASE_BITS-1:0] f_dly, s_dly, lim;
    logic [LEVEL_BITS-1:0] l1, l2;
    int sent, ticks, span, pick;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_FIRST_FIRE_DELAY;
    cfg_data = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.action = ACT_TICK;
    cmd_bus.level_one = '0;
    cmd_bus.level_two = '0;
    cmd_typed = 1'b0;
    cmd_want = BOTH_OFF;
    drv_bus.ready = 1'b0;

    // reset defaults, then equal delays held at the limit, zero level, limit below count
    dir_rows.push_back(ev_row(ACT_TICK, 8'h00, 8'h00, 1'b1, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_UNUSED, 8'hff, 8'hff, 1'b1, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_ZERO_CROSS, 8'hff, 8'h00, 1'b1, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_SET_LEVELS, 8'hff, 8'h00, 1'b1, BOTH_OFF));
    dir_rows.push_back(cfg_row(10'd2, 10'd2, 10'd2));
    dir_rows.push_back(ev_row(ACT_SET_LEVELS, 8'hff, 8'h01, 1'b0, BOTH_OFF));
    repeat (6) dir_rows.push_back(ev_row(ACT_TICK, 8'h00, 8'hff, 1'b0, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_ZERO_CROSS, 8'h00, 8'h00, 1'b0, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_SET_LEVELS, 8'h00, 8'h80, 1'b0, BOTH_OFF));
    repeat (3) dir_rows.push_back(ev_row(ACT_TICK, 8'hff, 8'h00, 1'b0, BOTH_OFF));
    dir_rows.push_back(cfg_row(10'd2, 10'd1023, 10'd1));
    repeat (3) dir_rows.push_back(ev_row(ACT_TICK, 8'h00, 8'h00, 1'b0, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_ZERO_CROSS, 8'h00, 8'h00, 1'b0, BOTH_OFF));
    dir_rows.push_back(ev_row(ACT_SET_LEVELS, 8'haa, 8'h55, 1'b0, BOTH_OFF));
    repeat (3) dir_rows.push_back(ev_row(ACT_TICK, 8'h00, 8'h00, 1'b0, BOTH_OFF));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) begin
        settle();
        set_config(dir_rows[i].first_delay, dir_rows[i].second_delay, dir_rows[i].limit);
      end else begin
        offer_event(dir_rows[i].act, dir_rows[i].lvl_one, dir_rows[i].lvl_two,
                    dir_rows[i].typed, dir_rows[i].want);
      end
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin f_dly = 10'd5; s_dly = 10'd20; lim = 10'd30;
           send_idle = 0; stall_pct <= 0; end
        1: begin f_dly = 10'd0; s_dly = 10'd1023; lim = 10'd1023;
           send_idle = 83; stall_pct <= 0; end
        2: begin f_dly = 10'd1; s_dly = 10'd1; lim = 10'd1;
           send_idle = 0; stall_pct <= 83; end
        4: begin f_dly = 10'd12; s_dly = 10'd40; lim = 10'd60;
           send_idle = 0; stall_pct <= 0; pressure_on <= 1'b1; end
        default: begin
          f_dly = PHASE_BITS'($urandom_range(40));
          s_dly = PHASE_BITS'($urandom_range(60));
          lim = PHASE_BITS'($urandom_range(64, 1));
          send_idle = 16;
          stall_pct <= 16;
        end
      endcase
      set_config(f_dly, s_dly, lim);
      span = (lim + 8 > 90) ? 90 : lim + 8;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) begin
          offer_event(ACT_ZERO_CROSS, LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
                      1'b0, BOTH_OFF);
          sent++;
        end
        ticks = $urandom_range(span, 1);
        for (int k = 0; k < ticks; k++) begin
          pick = $urandom_range(99);
          if (pick < 8) begin
            l1 = ($urandom_range(1) != 0) ? LEVEL_BITS'($urandom_range(15))
                                          : LEVEL_BITS'($urandom);
            l2 = ($urandom_range(1) != 0) ? LEVEL_BITS'($urandom_range(15))
                                          : LEVEL_BITS'($urandom);
            offer_event(ACT_SET_LEVELS, l1, l2, 1'b0, BOTH_OFF);
          end else if (pick < 11) begin
            offer_event(ACTION_BITS'($urandom_range(3)), LEVEL_BITS'($urandom),
                        LEVEL_BITS'($urandom), 1'b0, BOTH_OFF);
          end else begin
            offer_event(ACT_TICK, LEVEL_BITS'($urandom), LEVEL_BITS'($urandom),
                        1'b0, BOTH_OFF);
          end
          sent++;
        end
      end
      settle();
    end

    if (pending_drives.size() != 0) begin
      $display("%0d drive beats never arrived", pending_drives.size());
      failures++;
    end
    $display("events: %0d ticks, %0d zero-cross edges, %0d level sets, %0d unused codes",
             n_tick, n_zero, n_levels, n_unused);
    $display("%0d drive beats checked over %0d register settings, %0d firing points, %0d errors",
             beats_checked, cfg_settings, fire_points, failures);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("timeout with %0d drive beats pending", pending_drives.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
